// File: rtl/vitb_pkg.sv
// shared types, constants and the control program of the value intern table
package vitb_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
	localparam int KEY_W      = 32;
	localparam int QUERY_W    = 5;
	localparam int OUT_SLOT_W = 5;
	localparam int STATUS_W   = 2;
	localparam int STEP_W     = 4;

	typedef logic [STEP_W-1:0] step_t;

	// request kinds
	localparam logic REQ_INTERN = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd3;

	typedef enum logic [3:0] {
		C_NEVER     = 4'd0,
		C_ALWAYS    = 4'd1,
		C_NO_ACCEPT = 4'd2,
		C_LOOKUP    = 4'd3,
		C_EMPTY     = 4'd4,
		C_KEY_EQ    = 4'd5,
		C_WALK_MORE = 4'd6,
		C_FULL      = 4'd7,
		C_OUT_BUSY  = 4'd8
	} cond_t;

	typedef enum logic [1:0] {
		A_NONE  = 2'd0,
		A_NODE  = 2'd1,
		A_LINK  = 2'd2,
		A_QUERY = 2'd3
	} addr_sel_t;

	typedef enum logic [2:0] {
		R_NONE   = 3'd0,
		R_FOUND  = 3'd1,
		R_NEW    = 3'd2,
		R_FULL   = 3'd3,
		R_LOOKUP = 3'd4
	} res_sel_t;

	// one control word per program step
	typedef struct packed {
		logic      in_rdy;
		addr_sel_t addr;
		logic      walk;
		logic      wr_new;
		logic      wr_link;
		res_sel_t  res;
		cond_t     cond_a;
		step_t     tgt_a;
		cond_t     cond_b;
		step_t     tgt_b;
	} ucode_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic              accept;
		logic              lookup;
		logic              empty;
		logic              key_eq;
		logic              walk_more;
		logic              full;
		logic              out_busy;
		logic [FILL_W-1:0] fill;
	} stat_t;

	// program step addresses
	localparam step_t P_IDLE  = 4'd0;
	localparam step_t P_DISP  = 4'd1;
	localparam step_t P_RD0   = 4'd2;
	localparam step_t P_WALK  = 4'd3;
	localparam step_t P_CHKF  = 4'd4;
	localparam step_t P_INSA  = 4'd5;
	localparam step_t P_INSB  = 4'd6;
	localparam step_t P_RNEW  = 4'd7;
	localparam step_t P_FOUND = 4'd8;
	localparam step_t P_RFULL = 4'd9;
	localparam step_t P_LKRD  = 4'd10;
	localparam step_t P_LKRES = 4'd11;

	function automatic ucode_t uword(logic rdy, addr_sel_t a, logic wk, logic wn, logic wl,
		res_sel_t r, cond_t ca, step_t ta, cond_t cb, step_t tb);
		ucode_t w;
		w.in_rdy  = rdy;
		w.addr    = a;
		w.walk    = wk;
		w.wr_new  = wn;
		w.wr_link = wl;
		w.res     = r;
		w.cond_a  = ca;
		w.tgt_a   = ta;
		w.cond_b  = cb;
		w.tgt_b   = tb;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(step_t s);
		ucode_t w;
		case (s)
			P_IDLE:  w = uword(1'b1, A_NONE, 1'b0, 1'b0, 1'b0, R_NONE,
				C_NO_ACCEPT, P_IDLE, C_NEVER, P_IDLE);
			P_DISP:  w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_NONE,
				C_LOOKUP, P_LKRD, C_EMPTY, P_CHKF);
			P_RD0:   w = uword(1'b0, A_NODE, 1'b0, 1'b0, 1'b0, R_NONE,
				C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_WALK:  w = uword(1'b0, A_LINK, 1'b1, 1'b0, 1'b0, R_NONE,
				C_KEY_EQ, P_FOUND, C_WALK_MORE, P_WALK);
			P_CHKF:  w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_NONE,
				C_FULL, P_RFULL, C_NEVER, P_IDLE);
			P_INSA:  w = uword(1'b0, A_NONE, 1'b0, 1'b1, 1'b0, R_NONE,
				C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_INSB:  w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b1, R_NONE,
				C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_RNEW:  w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_NEW,
				C_OUT_BUSY, P_RNEW, C_ALWAYS, P_IDLE);
			P_FOUND: w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_FOUND,
				C_OUT_BUSY, P_FOUND, C_ALWAYS, P_IDLE);
			P_RFULL: w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_FULL,
				C_OUT_BUSY, P_RFULL, C_ALWAYS, P_IDLE);
			P_LKRD:  w = uword(1'b0, A_QUERY, 1'b0, 1'b0, 1'b0, R_NONE,
				C_NEVER, P_IDLE, C_NEVER, P_IDLE);
			P_LKRES: w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_LOOKUP,
				C_OUT_BUSY, P_LKRES, C_ALWAYS, P_IDLE);
			default: w = uword(1'b0, A_NONE, 1'b0, 1'b0, 1'b0, R_NONE,
				C_ALWAYS, P_IDLE, C_NEVER, P_IDLE);
		endcase
		return w;
	endfunction

endpackage

// File: rtl/vitb_if.sv
// request and response channel interfaces of the value intern table

interface vitb_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [vitb_pkg::KEY_W-1:0]   key_value;
	logic [vitb_pkg::QUERY_W-1:0] slot_query;

	modport source (output valid, output req_type, output key_value, output slot_query,
		input ready);
	modport sink (input valid, input req_type, input key_value, input slot_query,
		output ready);
endinterface

interface vitb_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [vitb_pkg::OUT_SLOT_W-1:0] slot_number;
	logic [vitb_pkg::KEY_W-1:0]      stored_value;
	logic [vitb_pkg::STATUS_W-1:0]   result_status;

	modport source (output valid, output slot_number, output stored_value,
		output result_status, input ready);
	modport sink (input valid, input slot_number, input stored_value,
		input result_status, output ready);
endinterface

// File: rtl/vitb_seq.sv
// microcode sequencer: step counter, control store and branch logic
module vitb_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  vitb_pkg::stat_t stat,
	output vitb_pkg::ucode_t ctl,
	output vitb_pkg::step_t  step
);
	import vitb_pkg::*;

	step_t step_q;
	step_t step_nxt;

	function automatic logic cond_true(cond_t c, stat_t st);
		logic r;
		case (c)
			C_NEVER:     r = 1'b0;
			C_ALWAYS:    r = 1'b1;
			C_NO_ACCEPT: r = !st.accept;
			C_LOOKUP:    r = st.lookup;
			C_EMPTY:     r = st.empty;
			C_KEY_EQ:    r = st.key_eq;
			C_WALK_MORE: r = st.walk_more;
			C_FULL:      r = st.full;
			C_OUT_BUSY:  r = st.out_busy;
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

	assign ctl  = ucode_rom(step_q);
	assign step = step_q;

	always_comb begin
		if (cond_true(ctl.cond_a, stat)) begin
			step_nxt = ctl.tgt_a;
		end else if (cond_true(ctl.cond_b, stat)) begin
			step_nxt = ctl.tgt_b;
		end else begin
			step_nxt = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= P_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// File: rtl/vitb_dpath.sv
// datapath: request latch, tree memories, walk registers, fill count and result register
module vitb_dpath (
	input  logic             clk,
	input  logic             arst_n,
	vitb_req_if.sink         req,
	vitb_rsp_if.source       rsp,
	input  vitb_pkg::ucode_t ctl,
	output vitb_pkg::stat_t  stat
);
	import vitb_pkg::*;

	// tree storage
	logic [KEY_W-1:0]  key_mem   [SLOT_COUNT];
	logic [SLOT_W-1:0] left_mem  [SLOT_COUNT];
	logic [SLOT_W-1:0] right_mem [SLOT_COUNT];

	logic [KEY_W-1:0]   key_q;
	logic               req_type_q;
	logic [QUERY_W-1:0] query_q;
	logic [SLOT_W-1:0]  node_q;
	logic [SLOT_W-1:0]  parent_q;
	logic               dir_left_q;
	logic [FILL_W-1:0]  steps_q;
	logic [FILL_W-1:0]  fill_q;

	logic [KEY_W-1:0]  rd_key_q;
	logic [SLOT_W-1:0] rd_left_q;
	logic [SLOT_W-1:0] rd_right_q;

	logic                  out_valid_q;
	logic [OUT_SLOT_W-1:0] out_slot_q;
	logic [KEY_W-1:0]      out_value_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic              accept;
	logic              go_left;
	logic [SLOT_W-1:0] link;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] fill_slot;
	logic              walk_more;
	logic              key_eq;
	logic              out_busy;
	logic              res_load;
	logic              q_unalloc;
	logic              lr_we;
	logic              rr_we;
	logic [SLOT_W-1:0] lr_addr;
	logic [SLOT_W-1:0] lr_data;

	assign req.ready = ctl.in_rdy;
	assign accept    = req.valid && ctl.in_rdy;

	assign key_eq    = (key_q == rd_key_q);
	assign go_left   = (key_q < rd_key_q);
	assign link      = go_left ? rd_left_q : rd_right_q;
	assign walk_more = (link != '0) && (FILL_W'(link) < FILL_W'(SLOT_COUNT)) &&
		(steps_q < FILL_W'(SLOT_COUNT - 1));
	assign fill_slot = fill_q[SLOT_W-1:0];
	assign q_unalloc = ((FILL_W + QUERY_W)'(query_q) >= (FILL_W + QUERY_W)'(fill_q));

	assign out_busy = out_valid_q && !rsp.ready;
	assign res_load = (ctl.res != R_NONE) && !out_busy;

	assign stat.accept    = accept;
	assign stat.lookup    = (req_type_q == REQ_LOOKUP);
	assign stat.empty     = (fill_q == '0);
	assign stat.key_eq    = key_eq;
	assign stat.walk_more = walk_more;
	assign stat.full      = (fill_q == FILL_W'(SLOT_COUNT));
	assign stat.out_busy  = out_busy;
	assign stat.fill      = fill_q;

	always_comb begin
		case (ctl.addr)
			A_NODE:  rd_addr = node_q;
			A_LINK:  rd_addr = link;
			A_QUERY: rd_addr = SLOT_W'(query_q);
			default: rd_addr = node_q;
		endcase
	end

	// child link writes: fresh entry clears, insert links the parent
	assign lr_addr = ctl.wr_new ? fill_slot : parent_q;
	assign lr_data = ctl.wr_new ? '0 : node_q;
	assign lr_we   = ctl.wr_new || (ctl.wr_link && dir_left_q);
	assign rr_we   = ctl.wr_new || (ctl.wr_link && !dir_left_q);

	always_ff @(posedge clk) begin
		if (ctl.wr_new) begin
			key_mem[fill_slot] <= key_q;
		end
		if (lr_we) begin
			left_mem[lr_addr] <= lr_data;
		end
		if (rr_we) begin
			right_mem[lr_addr] <= lr_data;
		end
		if (ctl.addr != A_NONE) begin
			rd_key_q   <= key_mem[rd_addr];
			rd_left_q  <= left_mem[rd_addr];
			rd_right_q <= right_mem[rd_addr];
		end
	end

	// request latch and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req.req_type;
			key_q      <= req.key_value;
			query_q    <= req.slot_query;
			node_q     <= '0;
			parent_q   <= '0;
			dir_left_q <= 1'b1;
			steps_q    <= '0;
		end else if (ctl.walk && !key_eq) begin
			parent_q   <= node_q;
			dir_left_q <= go_left;
			node_q     <= link;
			steps_q    <= steps_q + 1'b1;
		end else if (ctl.wr_new) begin
			node_q <= fill_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.wr_link) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			case (ctl.res)
				R_FOUND: begin
					out_slot_q   <= OUT_SLOT_W'(node_q);
					out_value_q  <= '0;
					out_status_q <= ST_FOUND;
				end
				R_NEW: begin
					out_slot_q   <= OUT_SLOT_W'(node_q);
					out_value_q  <= '0;
					out_status_q <= ST_NEW;
				end
				R_FULL: begin
					out_slot_q   <= '0;
					out_value_q  <= '0;
					out_status_q <= ST_FULL;
				end
				R_LOOKUP: begin
					out_slot_q   <= '0;
					out_value_q  <= q_unalloc ? '0 : rd_key_q;
					out_status_q <= q_unalloc ? ST_UNALLOC : ST_FOUND;
				end
				default: begin
					out_slot_q   <= '0;
					out_value_q  <= '0;
					out_status_q <= ST_FOUND;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.slot_number   = out_slot_q;
	assign rsp.stored_value  = out_value_q;
	assign rsp.result_status = out_status_q;

endmodule

// File: rtl/value_intern_table_bst.sv
// top level of the value intern table: microcode sequencer driving the tree datapath
// accept to result valid: a lookup reads its slot directly, while an intern request walks
// n tree nodes (n <= 32) before its result is loaded
// requests: one at a time, the next taken the cycle after the result is loaded
// reset: arst_n clears step counter, fill count and result valid; memories stay uncleared
module value_intern_table_bst (
	input  logic       clk,
	input  logic       arst_n,
	vitb_req_if.sink   req,
	vitb_rsp_if.source rsp
);
	import vitb_pkg::*;

	ucode_t ctl;
	stat_t  stat;
	step_t  step;

	// program sequencer: walks the control store, branches on datapath flags
	vitb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.step   (step)
	);

	// datapath: request latch, key and child-link memories, walk state,
	// fill count and the result register that decouples the response side
	vitb_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.stat   (stat)
	);

	// a request transaction always moves the program out of idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (!req.ready && step == P_DISP))
		else $error("request accepted but sequencer did not dispatch");

	// linking a new slot bumps the fill count by exactly one
	a_link_bumps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_link |=> (stat.fill == FILL_W'($past(stat.fill) + 1'b1)))
		else $error("fill count not advanced on insert");

	// the table never holds more slots than it has
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(SLOT_COUNT))
		else $error("fill count beyond table size");

	// an insert is only reached when a slot is free
	a_insert_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_new || ctl.wr_link) |-> !stat.full)
		else $error("insert attempted into a full table");

endmodule
